// ===== src/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps
`default_nettype none
package salru_pkg;

	localparam int ADDR_W = 64;
	localparam int CNT_W  = 32;

	// One result beat as produced by the back end.
	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} result_t;

endpackage
`default_nettype wire

// ===== src/salru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                         wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/salru_front.sv =====
// Front end: takes addresses, splits them into set and tag, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module salru_front import salru_pkg::*; #(
	parameter int SET_BITS    = 2,
	parameter int OFFSET_BITS = 4
) (
	input  wire                                           clk,
	input  wire                                           arst_n,
	input  wire                                           start,
	input  wire  [ADDR_W-1:0]                             address,
	input  wire                                           clearing,
	input  wire                                           pop,
	output logic                                          busy,
	output logic                                          q_valid,
	output logic [(SET_BITS > 0 ? SET_BITS : 1)-1:0]      q_set,
	output logic [ADDR_W-SET_BITS-OFFSET_BITS-1:0]        q_tag
);

	localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W = ADDR_W - SET_BITS - OFFSET_BITS;

	logic [SET_W-1:0] in_set;
	logic [TAG_W-1:0] in_tag;
	logic [SET_W-1:0] ent_set_q [2];
	logic [TAG_W-1:0] ent_tag_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;

	generate
		if (SET_BITS > 0) begin : g_set
			assign in_set = address[OFFSET_BITS +: SET_BITS];
		end else begin : g_noset
			assign in_set = '0;
		end
	endgenerate

	assign in_tag  = address[ADDR_W-1 : SET_BITS + OFFSET_BITS];
	assign busy    = clearing || (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_set   = ent_set_q[rd_ptr_q];
	assign q_tag   = ent_tag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_set_q[wr_ptr_q] <= in_set;
			ent_tag_q[wr_ptr_q] <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/salru_back.sv =====
// Back end: clears the tag store, then does one read-modify-write per queued access.
`timescale 1ns / 1ps
`default_nettype none
module salru_back import salru_pkg::*; #(
	parameter int SET_BITS    = 2,
	parameter int WAYS        = 4,
	parameter int OFFSET_BITS = 4
) (
	input  wire                                                  clk,
	input  wire                                                  arst_n,
	input  wire                                                  q_valid,
	input  wire  [(SET_BITS > 0 ? SET_BITS : 1)-1:0]             q_set,
	input  wire  [ADDR_W-SET_BITS-OFFSET_BITS-1:0]               q_tag,
	output logic                                                 pop,
	output logic                                                 clearing,
	output logic                                                 ram_we,
	output logic [(SET_BITS > 0 ? SET_BITS : 1)-1:0]             ram_waddr,
	output logic [WAYS*(1+(WAYS > 1 ? $clog2(WAYS) : 1)
	                   +ADDR_W-SET_BITS-OFFSET_BITS)-1:0]        ram_wdata,
	output logic [(SET_BITS > 0 ? SET_BITS : 1)-1:0]             ram_raddr,
	input  wire  [WAYS*(1+(WAYS > 1 ? $clog2(WAYS) : 1)
	                   +ADDR_W-SET_BITS-OFFSET_BITS)-1:0]        ram_rdata,
	output logic                                                 done,
	output result_t                                              result
);

	localparam int NUM_SETS = 1 << SET_BITS;
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_OFS = WAYS;
	localparam int TAG_OFS  = WAYS + WAYS * RW;

	typedef enum logic [1:0] {S_CLEAR, S_LOOKUP, S_UPDATE} state_t;

	state_t           state_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	logic [WAYS-1:0]  vld;
	logic [RW-1:0]    rank   [WAYS];
	logic [TAG_W-1:0] tag    [WAYS];
	logic [WAYS-1:0]  match;
	logic             hit;
	logic             inv_found;
	logic             evict;
	logic [RW-1:0]    hit_way;
	logic [RW-1:0]    inv_way;
	logic [RW-1:0]    lru_way;
	logic [RW-1:0]    victim;
	logic [RW:0]      old_rank;
	logic [WAYS-1:0]  new_vld;
	logic [RW-1:0]    new_rank [WAYS];
	logic [TAG_W-1:0] new_tag  [WAYS];
	logic [WAYS*(1+RW+TAG_W)-1:0] upd_row;

	// Unpack the row, look for the tag, and pick the way to touch.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			vld[w]   = ram_rdata[w];
			rank[w]  = ram_rdata[RANK_OFS + w*RW +: RW];
			tag[w]   = ram_rdata[TAG_OFS + w*TAG_W +: TAG_W];
			match[w] = vld[w] && (tag[w] == tag_q);
		end
		hit       = |match;
		inv_found = !(&vld);
		hit_way   = '0;
		inv_way   = '0;
		lru_way   = '0;
		// Walk downward so the lowest-numbered way wins.
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = RW'(w);
			end
			if (!vld[w]) begin
				inv_way = RW'(w);
			end
			if (rank[w] == RW'(WAYS - 1)) begin
				lru_way = RW'(w);
			end
		end
		priority if (hit) begin
			victim = hit_way;
		end else if (inv_found) begin
			victim = inv_way;
		end else begin
			victim = lru_way;
		end
		evict    = !hit && !inv_found;
		// Before a fill, the filled way's old rank counts as older than every other line, so all valid lines age.
		old_rank = hit ? {1'b0, rank[hit_way]} : (RW+1)'(WAYS);
		for (int w = 0; w < WAYS; w++) begin
			if (RW'(w) == victim) begin
				new_vld[w]  = 1'b1;
				new_rank[w] = '0;
				new_tag[w]  = tag_q;
			end else begin
				new_vld[w]  = vld[w];
				new_tag[w]  = tag[w];
				if (vld[w] && ({1'b0, rank[w]} < old_rank)) begin
					new_rank[w] = rank[w] + RW'(1);
				end else begin
					new_rank[w] = rank[w];
				end
			end
			upd_row[w]                          = new_vld[w];
			upd_row[RANK_OFS + w*RW +: RW]      = new_rank[w];
			upd_row[TAG_OFS + w*TAG_W +: TAG_W] = new_tag[w];
		end
	end

	assign clearing  = (state_q == S_CLEAR);
	assign pop       = (state_q == S_LOOKUP) && q_valid;
	assign ram_raddr = q_set;
	assign ram_we    = clearing || (state_q == S_UPDATE);
	assign ram_waddr = clearing ? clr_q : set_q;
	assign ram_wdata = clearing ? '0 : upd_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			set_q   <= '0;
			tag_q   <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (q_valid) begin
						set_q   <= q_set;
						tag_q   <= q_tag;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					done                  <= 1'b1;
					result.hit            <= hit;
					result.evicted        <= evict;
					result.hit_total      <= result.hit_total + CNT_W'(hit);
					result.miss_total     <= result.miss_total + CNT_W'(!hit);
					result.eviction_total <= result.eviction_total + CNT_W'(evict);
					state_q               <= S_LOOKUP;
				end
				default: begin
					state_q <= S_LOOKUP;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative LRU cache tag-store lookup.
// An accepted address is queued, then its tag-store row is read and written back, with done raised as it is written.
// The back end takes a new address only after the read then write-back of the previous tag-store row.
// A two-beat queue in front lets start be taken while the back end works on an earlier beat.
// Reset: arst_n clears control and totals, then a clearing pass writes 2**SET_BITS rows
// (one per cycle) with busy held high; the receiver of done cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_lookup import salru_pkg::*; #(
	parameter int SET_BITS    = 2,
	parameter int WAYS        = 4,
	parameter int OFFSET_BITS = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [ADDR_W-1:0] address,
	output logic              done,
	output logic              hit,
	output logic              evicted,
	output logic [CNT_W-1:0]  hit_total,
	output logic [CNT_W-1:0]  miss_total,
	output logic [CNT_W-1:0]  eviction_total
);

	localparam int NUM_SETS = 1 << SET_BITS;
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
	// One tag-store row holds a whole set: valid bits, recency ranks, then tags.
	localparam int ROW_W    = WAYS * (1 + RW + TAG_W);

	logic             clearing;
	logic             pop;
	logic             q_valid;
	logic [SET_W-1:0] q_set;
	logic [TAG_W-1:0] q_tag;
	logic             ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [SET_W-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	result_t          result;

	// The front end only splits and buffers; it holds busy while the queue is full
	// or while the tag store is still being cleared after reset.
	salru_front #(
		.SET_BITS    (SET_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.address  (address),
		.clearing (clearing),
		.pop      (pop),
		.busy     (busy),
		.q_valid  (q_valid),
		.q_set    (q_set),
		.q_tag    (q_tag)
	);

	// The back end reads a set in S_LOOKUP and writes the updated row back in S_UPDATE,
	// so consecutive accesses to the same set always see fresh data.
	salru_back #(
		.SET_BITS    (SET_BITS),
		.WAYS        (WAYS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_set     (q_set),
		.q_tag     (q_tag),
		.pop       (pop),
		.clearing  (clearing),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.done      (done),
		.result    (result)
	);

	salru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hit            = result.hit;
	assign evicted        = result.evicted;
	assign hit_total      = result.hit_total;
	assign miss_total     = result.miss_total;
	assign eviction_total = result.eviction_total;

endmodule
`default_nettype wire

// ===== src/salru_checker.sv =====
// Port-level checks for the cache lookup block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module salru_checker import salru_pkg::*; (
	input wire             clk,
	input wire             arst_n,
	input wire             done,
	input wire             hit,
	input wire             evicted,
	input wire [CNT_W-1:0] hit_total,
	input wire [CNT_W-1:0] miss_total,
	input wire [CNT_W-1:0] eviction_total
);

	// The back end needs a read and a write per beat, so strobes never abut.
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobes on consecutive cycles");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted))
		else $error("hit and evicted both set");

	// Each result beat adds exactly one access to the hit plus miss count.
	a_access_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CNT_W'(hit_total + miss_total)
			== CNT_W'($past(hit_total) + $past(miss_total) + CNT_W'(1))))
		else $error("access totals did not advance by one");

	// The eviction total follows the eviction flag.
	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (eviction_total == CNT_W'($past(eviction_total) + CNT_W'(evicted))))
		else $error("eviction total does not match flag");

	// Totals only move together with a result beat.
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> ($stable(hit_total) && $stable(miss_total) && $stable(eviction_total)))
		else $error("totals changed without a result beat");

endmodule

bind set_assoc_cache_lru_lookup salru_checker u_salru_checker (.*);
`default_nettype wire

// ===== tb/sv/cache_lookup_check.sv =====
// Watches the lookup channels, predicts each result and compares it with the block's output.
`timescale 1ns / 1ps
`default_nettype none
module cache_lookup_check import salru_pkg::*; #(
	parameter int SET_BITS    = 2,
	parameter int WAYS        = 4,
	parameter int OFFSET_BITS = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  wire  [ADDR_W-1:0] address,
	input  wire               done,
	input  wire               hit,
	input  wire               evicted,
	input  wire  [CNT_W-1:0]  hit_total,
	input  wire  [CNT_W-1:0]  miss_total,
	input  wire  [CNT_W-1:0]  eviction_total,
	output int                fail_count,
	output int                pending_beats
);

	localparam int NUM_LINES = (1 << SET_BITS) * WAYS;
	localparam int TAG_W     = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic             way_valid [NUM_LINES];
	logic [TAG_W-1:0] way_tag   [NUM_LINES];
	logic [AGE_W-1:0] way_age   [NUM_LINES];
	logic [CNT_W-1:0] hit_tally;
	logic [CNT_W-1:0] miss_tally;
	logic [CNT_W-1:0] evict_count;
	result_t          expected_results [$];
	int               mismatch_count;

	// Ages every valid way younger than old_age by one, then makes way w the newest.
	function automatic void promote_way(int base, int w, int old_age);
		for (int i = 0; i < WAYS; i++) begin
			if (i != w && way_valid[base + i] && int'(way_age[base + i]) < old_age)
				way_age[base + i] = way_age[base + i] + 1'b1;
		end
		way_age[base + w] = '0;
	endfunction

	function automatic result_t lookup_and_update(logic [ADDR_W-1:0] addr);
		logic [TAG_W-1:0] tag;
		int               base;
		int               victim;
		logic             found;
		logic             evict;
		result_t          r;
		tag    = addr[ADDR_W-1:SET_BITS+OFFSET_BITS];
		base   = int'(addr[OFFSET_BITS +: SET_BITS]) * WAYS;
		found  = 1'b0;
		evict  = 1'b0;
		victim = 0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && way_valid[base + i] && way_tag[base + i] == tag) begin
				found  = 1'b1;
				victim = i;
			end
		end
		if (found) begin
			hit_tally = hit_tally + 1'b1;
			promote_way(base, victim, int'(way_age[base + victim]));
		end else begin
			miss_tally = miss_tally + 1'b1;
			evict = 1'b1;
			for (int i = WAYS - 1; i >= 0; i--) begin
				if (!way_valid[base + i]) begin
					victim = i;
					evict  = 1'b0;
				end
			end
			if (evict) begin
				victim = 0;
				for (int i = 1; i < WAYS; i++) begin
					if (way_age[base + i] > way_age[base + victim])
						victim = i;
				end
				evict_count = evict_count + 1'b1;
			end
			way_valid[base + victim] = 1'b1;
			way_tag[base + victim]   = tag;
			promote_way(base, victim, WAYS);
		end
		r.hit            = found;
		r.evicted        = evict;
		r.hit_total      = hit_tally;
		r.miss_total     = miss_tally;
		r.eviction_total = evict_count;
		return r;
	endfunction

	function automatic void check_field(string field, logic [CNT_W-1:0] want_v,
			logic [CNT_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				way_valid[i] = 1'b0;
				way_tag[i]   = '0;
				way_age[i]   = '0;
			end
			hit_tally   = '0;
			miss_tally  = '0;
			evict_count = '0;
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, actual hit=%0b total=%0h",
						$time, hit, hit_total);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("hit", want.hit, hit);
					check_field("evicted", want.evicted, evicted);
					check_field("hit_total", want.hit_total, hit_total);
					check_field("miss_total", want.miss_total, miss_total);
					check_field("eviction_total", want.eviction_total, eviction_total);
				end
			end
			if (start && !busy)
				expected_results.push_back(lookup_and_update(address));
		end
		pending_beats <= expected_results.size();
		fail_count    <= mismatch_count;
	end

endmodule
`default_nettype wire

// ===== tb/sv/set_assoc_cache_lru_lookup_tb.sv =====
// Testbench top for the set-associative LRU cache lookup: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_lookup_tb;
	import salru_pkg::*;

	localparam int SET_BITS    = 2;
	localparam int WAYS        = 4;
	localparam int OFFSET_BITS = 4;
	localparam int TAG_W       = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int RANDOM_BEATS = 900;
	localparam int TAG_POOL     = 6;
	// The slowest correct run is 917 beats, each followed by the longest gap that pick_gap
	// can return plus the block's own handling; CYCLE_LIMIT leaves a wide margin.
	localparam int CYCLE_LIMIT  = 400000;

	logic              clk;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	wire               busy;
	wire               done;
	wire               hit;
	wire               evicted;
	wire  [CNT_W-1:0]  hit_total;
	wire  [CNT_W-1:0]  miss_total;
	wire  [CNT_W-1:0]  eviction_total;
	int                fail_count;
	int                pending_beats;
	int                cycle_count = 0;
	int                calm_left   = 0;
	logic [TAG_W-1:0]  tag_pool [TAG_POOL];

	set_assoc_cache_lru_lookup #(
		.SET_BITS   (SET_BITS),
		.WAYS       (WAYS),
		.OFFSET_BITS(OFFSET_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.hit           (hit),
		.evicted       (evicted),
		.hit_total     (hit_total),
		.miss_total    (miss_total),
		.eviction_total(eviction_total)
	);

	cache_lookup_check #(
		.SET_BITS   (SET_BITS),
		.WAYS       (WAYS),
		.OFFSET_BITS(OFFSET_BITS)
	) lookup_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.hit           (hit),
		.evicted       (evicted),
		.hit_total     (hit_total),
		.miss_total    (miss_total),
		.eviction_total(eviction_total),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a result that never arrives ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Idle length between beats. Most gaps are short, a few are long, and now and
	// then a calm stretch sends beats back to back so the two-beat queue fills up.
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(15, 50);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [TAG_W-1:0] random_tag();
		return TAG_W'({$urandom, $urandom});
	endfunction

	// Most addresses reuse a small pool of tags so that sets fill up and hits,
	// refills and evictions all happen often. Small tags and fully random
	// addresses make up the rest, the latter toggling every address bit.
	function automatic logic [ADDR_W-1:0] pick_address();
		int                   r;
		logic [SET_BITS-1:0]  set_sel;
		logic [OFFSET_BITS-1:0] offset;
		r       = $urandom_range(0, 99);
		set_sel = SET_BITS'($urandom);
		offset  = OFFSET_BITS'($urandom);
		if (r < 75)
			return {tag_pool[$urandom_range(0, TAG_POOL - 1)], set_sel, offset};
		if (r < 87)
			return {TAG_W'($urandom_range(0, 7)), set_sel, offset};
		return {$urandom, $urandom};
	endfunction

	// Presents one address beat and holds it until the block takes it. When an idle
	// gap follows, start drops and the address bus carries junk the block must ignore.
	task automatic send_beat(input logic [ADDR_W-1:0] addr, input int idle_after);
		start   <= 1'b1;
		address <= addr;
		do @(posedge clk); while (busy);
		if (idle_after > 0) begin
			start   <= 1'b0;
			address <= {$urandom, $urandom};
			repeat (idle_after) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		for (int i = 0; i < TAG_POOL; i++)
			tag_pool[i] = random_tag();

		// Reset is held at the start; the block then clears its tag store with
		// busy high, which send_beat waits out through the handshake.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A miss into an empty set, then the same block at another
		// offset, which must hit.
		send_beat(64'h0000_0000_0000_0000, pick_gap());
		send_beat(64'h0000_0000_0000_000F, pick_gap());
		// All-ones address, then one whose tag differs only in the top bit: the
		// full tag is compared, so the second is a miss and the third a hit.
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
		send_beat(64'h7FFF_FFFF_FFFF_FFFF, pick_gap());
		send_beat(64'hFFFF_FFFF_FFFF_FFF0, pick_gap());
		// Fill the remaining ways of set 0 in order, lowest invalid way first.
		send_beat(64'h0000_0000_0000_0040, pick_gap());
		send_beat(64'h0000_0000_0000_0080, pick_gap());
		send_beat(64'h0000_0000_0000_00C0, pick_gap());
		// A hit on the oldest way makes it newest, so the next misses evict the
		// least recent lines in turn instead of it.
		send_beat(64'h0000_0000_0000_0000, pick_gap());
		send_beat(64'h0000_0000_0000_0100, pick_gap());
		send_beat(64'h0000_0000_0000_0040, pick_gap());
		send_beat(64'h8000_0000_0000_0000, pick_gap());
		send_beat(64'h0000_0000_0000_0000, 0);
		send_beat(64'h0000_0000_0000_0000, 0);
		// The other sets, back to back with offsets 0, 5 and A.
		send_beat(64'h0000_0000_0000_0010, 0);
		send_beat(64'h0000_0000_0000_0025, 0);
		send_beat(64'h0000_0000_0000_003A, pick_gap());

		// Random part, with the tag pool slowly churning so new tags keep arriving.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 49) == 0)
				tag_pool[$urandom_range(0, TAG_POOL - 1)] = random_tag();
			send_beat(pick_address(), pick_gap());
		end
		start <= 1'b0;

		// Drain: the watchdog covers a result that never shows up. The extra
		// cycles afterwards catch any stray result beat.
		while (pending_beats != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
